@@ hdl/fbpb_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpb_pkg
// Shared constants, command type and blend helper for the framebuffer pixel
// blend port.
// ----------------------------------------------------------------------------
package fbpb_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PIX_W        = 24;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] OP_READ    = 8'h00;
	localparam logic [7:0] OP_WRITE   = 8'h01;
	localparam logic [7:0] ALPHA_NONE = 8'h00;
	localparam logic [7:0] ALPHA_FULL = 8'hFF;
	localparam logic [7:0] READ_MARK  = 8'h80;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_BLEND = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  rgb;
		logic [7:0]        alpha;
	} cmd_t;

	// floor(v / 255) for v up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] s;
		s = 17'(v) + 17'd1 + 17'(v[15:8]);
		return s[15:8];
	endfunction

endpackage

@@ hdl/fbpb_req_if.sv @@
// ----------------------------------------------------------------------------
// fbpb_req_if
// Pixel request channel: coordinates, opcode and RGBA color.
// ----------------------------------------------------------------------------
interface fbpb_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] x_coord;
	logic [15:0] y_coord;
	logic [7:0]  opcode;
	logic [31:0] color;

	modport source (output valid, x_coord, y_coord, opcode, color, input ready);
	modport sink   (input valid, x_coord, y_coord, opcode, color, output ready);
endinterface

@@ hdl/fbpb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fbpb_rsp_if
// Read reply channel: status byte and stored red, green, blue.
// ----------------------------------------------------------------------------
interface fbpb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, status_byte, red, green, blue, input ready);
	modport sink   (input valid, status_byte, red, green, blue, output ready);
endinterface

@@ hdl/fbpb_ram.sv @@
// ----------------------------------------------------------------------------
// fbpb_ram
// Generic single-port RAM, one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module fbpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/fbpb_front.sv @@
// ----------------------------------------------------------------------------
// fbpb_front
// Accepts pixel requests, drops out-of-frame and no-op items, and turns the
// rest into read, store or blend commands for the queue.
// ----------------------------------------------------------------------------
module fbpb_front (
	fbpb_req_if.sink     req,
	input  logic         q_full,
	input  logic         clear_busy,
	output logic         push,
	output fbpb_pkg::cmd_t push_cmd
);
	import fbpb_pkg::*;

	logic        in_range;
	logic        useful;
	logic [31:0] lin;

	assign req.ready = !q_full && !clear_busy;

	assign in_range = (req.x_coord < 16'(FRAME_WIDTH)) && (req.y_coord < 16'(FRAME_HEIGHT));
	assign lin      = 32'(req.y_coord) * 32'(FRAME_WIDTH) + 32'(req.x_coord);

	always_comb begin
		push_cmd.addr  = lin[ADDR_W-1:0];
		push_cmd.rgb   = req.color[31:8];
		push_cmd.alpha = req.color[7:0];
		push_cmd.kind  = CMD_READ;
		useful         = 1'b0;
		if (req.opcode == OP_READ) begin
			useful = 1'b1;
		end else if (req.opcode == OP_WRITE && req.color[7:0] != ALPHA_NONE) begin
			useful        = 1'b1;
			push_cmd.kind = (req.color[7:0] == ALPHA_FULL) ? CMD_WRITE : CMD_BLEND;
		end
	end

	assign push = req.valid && req.ready && in_range && useful;

endmodule

@@ hdl/fbpb_queue.sv @@
// ----------------------------------------------------------------------------
// fbpb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fbpb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbpb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output fbpb_pkg::cmd_t head,
	output logic           not_empty,
	output logic           full
);
	import fbpb_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/fbpb_back.sv @@
// ----------------------------------------------------------------------------
// fbpb_back
// Owns the framebuffer RAM: clears it after reset, then executes queued
// commands one at a time (read reply, direct store, read-blend-write).
// ----------------------------------------------------------------------------
module fbpb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  fbpb_pkg::cmd_t head,
	output logic           pop,
	output logic           clear_busy,
	fbpb_rsp_if.source     rsp
);
	import fbpb_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;
	localparam logic [1:0] ST_BLEND = 2'd3;

	logic [1:0]        st_q;
	logic [1:0]        st_d;
	logic [ADDR_W-1:0] clr_q;
	cmd_t              cur_q;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [PIX_W-1:0]  ram_rdata;

	logic [15:0]       prod_r_q;
	logic [15:0]       prod_g_q;
	logic [15:0]       prod_b_q;
	logic [15:0]       mix_r;
	logic [15:0]       mix_g;
	logic [15:0]       mix_b;
	logic [7:0]        keep;

	logic              out_valid_q;
	logic [PIX_W-1:0]  out_rgb_q;
	logic              out_load;

	fbpb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign clear_busy = (st_q == ST_CLEAR);
	assign out_load   = (st_q == ST_FETCH) && (cur_q.kind == CMD_READ)
		&& (!out_valid_q || rsp.ready);

	// old*(255-t) + new*t per channel
	assign keep  = ALPHA_FULL - cur_q.alpha;
	assign mix_r = 16'(ram_rdata[23:16]) * 16'(keep) + 16'(cur_q.rgb[23:16]) * 16'(cur_q.alpha);
	assign mix_g = 16'(ram_rdata[15:8])  * 16'(keep) + 16'(cur_q.rgb[15:8])  * 16'(cur_q.alpha);
	assign mix_b = 16'(ram_rdata[7:0])   * 16'(keep) + 16'(cur_q.rgb[7:0])   * 16'(cur_q.alpha);

	always_comb begin
		st_d      = st_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = head.addr;
		ram_wdata = head.rgb;
		case (st_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (head.kind == CMD_WRITE) begin
						ram_we = 1'b1;
					end else begin
						ram_re = 1'b1;
						st_d   = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				if (cur_q.kind != CMD_READ) begin
					st_d = ST_BLEND;
				end else if (out_load) begin
					st_d = ST_IDLE;
				end
			end
			ST_BLEND: begin
				ram_we    = 1'b1;
				ram_addr  = cur_q.addr;
				ram_wdata = {div255(prod_r_q), div255(prod_g_q), div255(prod_b_q)};
				st_d      = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (st_q == ST_FETCH) begin
			prod_r_q <= mix_r;
			prod_g_q <= mix_g;
			prod_b_q <= mix_b;
		end
		if (out_load) begin
			out_rgb_q <= ram_rdata;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status_byte = READ_MARK;
	assign rsp.red         = out_rgb_q[23:16];
	assign rsp.green       = out_rgb_q[15:8];
	assign rsp.blue        = out_rgb_q[7:0];

endmodule

@@ hdl/framebuffer_pixel_blend_port_top.sv @@
// ----------------------------------------------------------------------------
// framebuffer_pixel_blend_port_top
// Framebuffer pixel port with read replies and alpha-blended writes.
//
//   Channel  Dir  Carries
//   req      in   x_coord, y_coord, opcode, color (RGBA)
//   rsp      out  status_byte, red, green, blue (in-frame reads only)
//
// The front takes one request per cycle, while req.ready is high, into a
// two-entry command queue. The back uses the single RAM port: a full-alpha
// store is one write, a read a RAM read then a reply load, a blend a read,
// a multiply, then a divide and write. After reset the RAM is cleared one
// word a cycle, FRAME_WIDTH*FRAME_HEIGHT (4096) words, with req.ready low.
// req.ready drops while the queue is full; a stalled reply holds the back.
// ----------------------------------------------------------------------------
module framebuffer_pixel_blend_port_top (
	input  logic       clk,
	input  logic       arst_n,
	fbpb_req_if.sink   req,
	fbpb_rsp_if.source rsp
);
	import fbpb_pkg::*;

	logic q_full;
	logic q_not_empty;
	logic clear_busy;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	fbpb_front u_front (
		.req        (req),
		.q_full     (q_full),
		.clear_busy (clear_busy),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	fbpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	fbpb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.rsp        (rsp)
	);

endmodule

@@ hdl/fbpb_checker.sv @@
// ----------------------------------------------------------------------------
// fbpb_checker
// Port-level checks for the framebuffer pixel blend port.
// ----------------------------------------------------------------------------
module fbpb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  rsp_status_byte,
	input logic [23:0] rsp_rgb
);
	import fbpb_pkg::*;

	// every reply carries the read marker
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status_byte == READ_MARK)
		else $error("reply without read marker");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rgb))
		else $error("stalled reply changed");

	// the clearing sweep keeps requests out right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready && !rsp_valid)
		else $error("request taken during clear");

	// a read needs at least a queue hop and a RAM read before its reply
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(arst_n) && $past(arst_n, 2))
		else $error("reply too soon after reset");

endmodule

bind framebuffer_pixel_blend_port_top fbpb_checker u_fbpb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status_byte (rsp.status_byte),
	.rsp_rgb         ({rsp.red, rsp.green, rsp.blue})
);

@@ bench/fbpb_blend_checker.sv @@
// ----------------------------------------------------------------------------
// fbpb_blend_checker
// Watches the request and reply channels of the pixel blend port. It keeps a
// shadow framebuffer, predicts the reply of every in-frame read and compares
// each reply, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module fbpb_blend_checker (
	input  logic clk,
	input  logic arst_n,
	fbpb_req_if  req,
	fbpb_rsp_if  rsp,
	output int   errors,
	output int   owed
);

	import fbpb_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} reply_t;

	logic [PIX_W-1:0] shadow_pixels [STORE_DEPTH];
	reply_t           owed_replies [$];

	// exact floor((old*(255-alpha) + new*alpha) / 255)
	function automatic logic [7:0] blend_channel(input logic [7:0] old_v,
			input logic [7:0] new_v, input logic [7:0] alpha);
		int unsigned acc;
		acc = int'(old_v) * (255 - int'(alpha)) + int'(new_v) * int'(alpha);
		return 8'(acc / 255);
	endfunction

	task automatic report_reply(input string what, input reply_t want, input reply_t got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%s: expected %h/%h/%h/%h got %h/%h/%h/%h", what,
				want.status_byte, want.red, want.green, want.blue,
				got.status_byte, got.red, got.green, got.blue);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int               addr;
		logic [PIX_W-1:0] word;
		logic [7:0]       alpha;
		reply_t           got;
		reply_t           want;
		if (!arst_n) begin
			foreach (shadow_pixels[i])
				shadow_pixels[i] = '0;
			owed_replies.delete();
			errors = 0;
			owed   = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status_byte, rsp.red, rsp.green, rsp.blue};
				if (owed_replies.size() == 0) begin
					report_reply("unexpected reply", '0, got);
				end else begin
					want = owed_replies.pop_front();
					if (got.status_byte !== want.status_byte || got.red !== want.red ||
							got.green !== want.green || got.blue !== want.blue)
						report_reply("reply mismatch", want, got);
				end
			end
			// drop anything outside the frame
			if (req.valid && req.ready && req.x_coord < FRAME_WIDTH &&
					req.y_coord < FRAME_HEIGHT) begin
				addr = int'(req.y_coord) * FRAME_WIDTH + int'(req.x_coord);
				word = shadow_pixels[addr];
				if (req.opcode == OP_READ) begin
					owed_replies.push_back({READ_MARK, word[23:16], word[15:8], word[7:0]});
				end else if (req.opcode == OP_WRITE) begin
					alpha = req.color[7:0];
					if (alpha == ALPHA_FULL)
						shadow_pixels[addr] = req.color[31:8];
					else if (alpha != ALPHA_NONE)
						shadow_pixels[addr] = {
							blend_channel(word[23:16], req.color[31:24], alpha),
							blend_channel(word[15:8], req.color[23:16], alpha),
							blend_channel(word[7:0], req.color[15:8], alpha)};
				end
			end
			owed = owed_replies.size();
		end
	end

endmodule

@@ bench/framebuffer_pixel_blend_port_top_tb.sv @@
// ----------------------------------------------------------------------------
// framebuffer_pixel_blend_port_top_tb
// Drives pixel requests into the blend port: a directed set of corner cases,
// then random traffic aimed at a few hot pixels so that writes, blends and
// reads meet. The sender works in bursts, the receiver stalls at random, and
// the checker beside the block scores every reply.
// ----------------------------------------------------------------------------
module framebuffer_pixel_blend_port_top_tb;

	import fbpb_pkg::*;

	localparam int ITEM_GOAL    = 1000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] OP_OTHER = 8'h02;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   owed;
	int   cycles = 0;
	int   burst_left = 0;
	int   pixels_sent = 0;

	fbpb_req_if req ();
	fbpb_rsp_if rsp ();

	framebuffer_pixel_blend_port_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	fbpb_blend_checker scoreboard (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.errors (errors),
		.owed   (owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: runs of ready and stall, now and then a long run with no stall
	initial begin : reply_stall
		int   run;
		logic level;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			case ($urandom_range(0, 5))
				0: begin
					level = 1'b1;
					run   = $urandom_range(50, 200);
				end
				1, 2, 3: begin
					level = 1'b1;
					run   = $urandom_range(1, 12);
				end
				default: begin
					level = 1'b0;
					run   = $urandom_range(1, 8);
				end
			endcase
			rsp.ready <= level;
			repeat (run) @(posedge clk);
		end
	end

	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
			input logic [7:0] op, input logic [31:0] color);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid   <= 1'b1;
		req.x_coord <= x;
		req.y_coord <= y;
		req.opcode  <= op;
		req.color   <= color;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return ALPHA_NONE;
		if (r < 40)
			return ALPHA_FULL;
		if (r < 45)
			return 8'd1;
		if (r < 50)
			return 8'd254;
		return 8'($urandom);
	endfunction

	initial begin : stimulus
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  op;
		int          r;
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.x_coord <= '0;
		req.y_coord <= '0;
		req.opcode  <= '0;
		req.color   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners after reset, full store, no-op write, blends
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd63, 16'd63, OP_READ, 32'hFFFF_FFFF);
		send_pixel(16'd0, 16'd0, OP_WRITE, {24'hFF_FF_FF, ALPHA_FULL});
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd0, 16'd0, OP_WRITE, {24'h00_00_00, ALPHA_NONE});
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd0, 16'd0, OP_WRITE, {24'h00_00_00, 8'd1});
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd0, 16'd0, OP_WRITE, {24'h00_00_00, 8'd254});
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd63, 16'd63, OP_WRITE, {24'hFF_80_01, 8'd128});
		send_pixel(16'd63, 16'd63, OP_READ, 32'h0);
		send_pixel(16'd63, 16'd0, OP_WRITE, {24'h12_34_56, ALPHA_FULL});
		send_pixel(16'd0, 16'd63, OP_WRITE, {24'hAB_CD_EF, ALPHA_FULL});
		send_pixel(16'd63, 16'd0, OP_READ, 32'h0);
		send_pixel(16'd0, 16'd63, OP_READ, 32'h0);
		// out of frame: must neither answer nor touch the store
		send_pixel(16'd64, 16'd0, OP_WRITE, {24'h11_22_33, ALPHA_FULL});
		send_pixel(16'd0, 16'd64, OP_WRITE, {24'h11_22_33, ALPHA_FULL});
		send_pixel(16'hFFFF, 16'hFFFF, OP_READ, 32'h0);
		send_pixel(16'hFFFF, 16'd0, OP_READ, 32'h0);
		// unknown opcodes are ignored
		send_pixel(16'd0, 16'd0, OP_OTHER, {24'h55_55_55, ALPHA_FULL});
		send_pixel(16'd0, 16'd0, 8'hFF, {24'hAA_AA_AA, ALPHA_FULL});
		send_pixel(16'd0, 16'd0, OP_READ, 32'h0);

		while (pixels_sent < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				x = 16'($urandom);
				y = 16'($urandom);
				case ($urandom_range(0, 2))
					0: x = 16'($urandom_range(FRAME_WIDTH, 65535));
					1: y = 16'($urandom_range(FRAME_HEIGHT, 65535));
					default: begin
						x = 16'($urandom_range(FRAME_WIDTH, 65535));
						y = 16'($urandom_range(FRAME_HEIGHT, 65535));
					end
				endcase
			end else if (r < 60) begin
				// hot corner: keeps writes and reads on the same pixels
				x = 16'($urandom_range(0, 3));
				y = 16'($urandom_range(0, 3));
			end else begin
				x = 16'($urandom_range(0, FRAME_WIDTH - 1));
				y = 16'($urandom_range(0, FRAME_HEIGHT - 1));
			end
			r = $urandom_range(0, 99);
			if (r < 45)
				op = OP_READ;
			else if (r < 90)
				op = OP_WRITE;
			else
				op = 8'($urandom_range(2, 255));
			send_pixel(x, y, op, {24'($urandom), pick_alpha()});
			pixels_sent++;
		end
		req.valid <= 1'b0;

		// let the checker see the last accepted item before polling it
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ framebuffer_pixel_blend_port_top.f @@
hdl/fbpb_pkg.sv
hdl/fbpb_req_if.sv
hdl/fbpb_rsp_if.sv
hdl/fbpb_ram.sv
hdl/fbpb_front.sv
hdl/fbpb_queue.sv
hdl/fbpb_back.sv
hdl/framebuffer_pixel_blend_port_top.sv
hdl/fbpb_checker.sv
bench/fbpb_blend_checker.sv
bench/framebuffer_pixel_blend_port_top_tb.sv
